### hw/rtl/assert_macros.svh
// Assertion macros for the RTL files.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge, off while reset is high.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Plain property checked on every rising clock edge, off while reset is high.
`define ASSERT_ALWAYS(label, clk, rst, expr, msg) \
   `ASSERT_CLK(label, clk, rst, (expr), msg)

`endif

### hw/rtl/pcrt_pkg.sv
// Shared types, constants and helper functions for the point cloud rigid transform.
// No dependencies.
package pcrt_pkg;

   localparam int COORD_W     = 32;            // Q16.16 coordinate
   localparam int ANGLE_W     = 16;            // Q2.13 radians
   localparam int TRIG_W      = 18;            // Q1.16 cosine / sine
   localparam int CORD_W      = 34;            // Q2.30 CORDIC datapath (with headroom)
   localparam int PROD_W      = TRIG_W + COORD_W;
   localparam int SUM_W       = PROD_W + 1;
   localparam int RND_W       = SUM_W - 16;
   localparam int FIN_W       = RND_W + 1;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 32;

   localparam int ATAN_ENTRIES  = 24;
   localparam int STEP_W        = $clog2(ATAN_ENTRIES);
   localparam int CORDIC_STEPS_DEFAULT = 16;

   localparam logic [CSR_INDEX_W-1:0] REG_OFFSET_X       = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_OFFSET_Y       = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_ROTATION_ANGLE = 2'd2;

   localparam logic signed [CORD_W-1:0] CORDIC_GAIN_Q30 = 34'sh026DD3B6A;
   localparam logic signed [ANGLE_W:0]  PI_Q13          = 17'sd25736;
   localparam logic signed [ANGLE_W:0]  HALF_PI_Q13     = 17'sd12868;
   localparam logic signed [ANGLE_W-1:0] TINY_ANGLE     = 16'sd8;
   localparam logic signed [TRIG_W-1:0] ONE_Q16         = 18'sd65536;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic signed [TRIG_W-1:0]  trig_type;

   function automatic logic signed [CORD_W-1:0] atan_q30(input logic [STEP_W-1:0] idx);
      logic signed [CORD_W-1:0] v;
      case (idx)
         5'd0:    v = 34'sh03243F6A8;
         5'd1:    v = 34'sh01DAC6705;
         5'd2:    v = 34'sh00FADBAFC;
         5'd3:    v = 34'sh007F56EA6;
         5'd4:    v = 34'sh003FEAB76;
         5'd5:    v = 34'sh001FFD55B;
         5'd6:    v = 34'sh000FFFAAA;
         5'd7:    v = 34'sh0007FFF55;
         5'd8:    v = 34'sh0003FFFEA;
         5'd9:    v = 34'sh0001FFFFD;
         5'd10:   v = 34'sh0000FFFFF;
         5'd11:   v = 34'sh00007FFFF;
         5'd12:   v = 34'sh00003FFFF;
         5'd13:   v = 34'sh00001FFFF;
         5'd14:   v = 34'sh00000FFFF;
         5'd15:   v = 34'sh000007FFF;
         5'd16:   v = 34'sh000003FFF;
         5'd17:   v = 34'sh000001FFF;
         5'd18:   v = 34'sh000000FFF;
         5'd19:   v = 34'sh0000007FF;
         5'd20:   v = 34'sh0000003FF;
         5'd21:   v = 34'sh0000001FF;
         5'd22:   v = 34'sh0000000FF;
         5'd23:   v = 34'sh00000007F;
         default: v = '0;
      endcase
      return v;
   endfunction

   // Q2.30 -> Q1.16, round half up, clamp to [-1.0, 1.0]
   function automatic trig_type to_q16(input logic signed [CORD_W-1:0] v);
      logic signed [CORD_W:0]    t;
      logic signed [CORD_W-14:0] r;
      trig_type                  q;
      t = {v[CORD_W-1], v} + (CORD_W+1)'(8192);
      r = (CORD_W-13)'(t >>> 14);
      if (r > (CORD_W-13)'(65536))
         q = ONE_Q16;
      else if (r < -(CORD_W-13)'(65536))
         q = -ONE_Q16;
      else
         q = TRIG_W'(r);
      return q;
   endfunction

   function automatic coord_type sat32(input logic signed [FIN_W-1:0] v);
      coord_type q;
      if (v > FIN_W'(32'sh7FFFFFFF))
         q = 32'sh7FFFFFFF;
      else if (v < -FIN_W'(33'sh080000000))
         q = 32'sh80000000;
      else
         q = COORD_W'(v);
      return q;
   endfunction

endpackage

### hw/rtl/point_cloud_rigid_transform_unit.sv
// Point cloud rigid transform: rotation + translation of a Q16.16 point stream.
// Depends on pcrt_pkg and assert_macros.svh.

// Each point beat (x, y) becomes (c*x - s*y + offset_x, s*x + c*y + offset_y), rounded
// and saturated to 32 bits, with tlast passed through. The datapath takes one point per
// cycle while the output is not stalled and has four register stages (input, products,
// rounded sums, offset and saturate). Cosine and sine come from an iterative CORDIC that
// starts after reset and after every write of the rotation angle; it runs CORDIC_STEPS
// iterations (capped at 24) between its load and finish states, or stops in the load state
// for an angle within +/-8 units, where the block only translates. Until it finishes, the
// first point of a scan waits; points inside a running scan keep flowing. The angle in
// use is the one in force at the first point of a scan and holds until its last point.
module point_cloud_rigid_transform_unit
   import pcrt_pkg::*;
#(
   parameter int CORDIC_STEPS = CORDIC_STEPS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [2*COORD_W-1:0]   req_tdata,   // [31:0] point_x, [63:32] point_y
   input  logic                   req_tlast,   // last_point
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [2*COORD_W-1:0]   rsp_tdata,   // [31:0] out_x, [63:32] out_y
   output logic                   rsp_tlast,   // out_last
   input  logic                   csr_wen,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

`include "assert_macros.svh"

   localparam int STEPS_EFF = (CORDIC_STEPS < ATAN_ENTRIES) ? CORDIC_STEPS : ATAN_ENTRIES;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_LOAD   = 2'd1;
   localparam logic [1:0] ST_ITER   = 2'd2;
   localparam logic [1:0] ST_FINISH = 2'd3;

   // ---------------- configuration ----------------
   coord_type                 offset_x_ff, offset_y_ff;
   logic signed [ANGLE_W-1:0] angle_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_x_ff <= '0;
         offset_y_ff <= '0;
         angle_ff    <= '0;
      end else if (csr_wen) begin
         case (csr_index)
            REG_OFFSET_X:       offset_x_ff <= csr_wdata[COORD_W-1:0];
            REG_OFFSET_Y:       offset_y_ff <= csr_wdata[COORD_W-1:0];
            REG_ROTATION_ANGLE: angle_ff    <= csr_wdata[ANGLE_W-1:0];
            default: ;
         endcase
      end
   end

   wire angle_wr = csr_wen && (csr_index == REG_ROTATION_ANGLE);

   // ---------------- CORDIC sequencer ----------------
   logic [1:0]               cst_ff, cst_in;
   logic [STEP_W-1:0]        step_ff, step_in;
   logic signed [CORD_W-1:0] cx_ff, cy_ff, cz_ff, cx_in, cy_in, cz_in;
   logic                     neg_ff, neg_in;
   trig_type                 next_cos_ff, next_sin_ff, next_cos_in, next_sin_in;
   logic signed [ANGLE_W:0]  a_wide, a_fold;
   logic signed [CORD_W-1:0] sh_x, sh_y;
   logic                     tiny_angle;

   assign tiny_angle = (angle_ff >= -TINY_ANGLE) && (angle_ff <= TINY_ANGLE);

   always_comb begin
      cst_in      = cst_ff;
      step_in     = step_ff;
      cx_in       = cx_ff;
      cy_in       = cy_ff;
      cz_in       = cz_ff;
      neg_in      = neg_ff;
      next_cos_in = next_cos_ff;
      next_sin_in = next_sin_ff;
      a_wide      = {angle_ff[ANGLE_W-1], angle_ff};
      a_fold      = a_wide;
      sh_x        = cx_ff >>> step_ff;
      sh_y        = cy_ff >>> step_ff;
      case (cst_ff)
         ST_LOAD: begin
            if (tiny_angle) begin
               next_cos_in = ONE_Q16;
               next_sin_in = '0;
               cst_in      = ST_IDLE;
            end else begin
               // fold into [-pi/2, pi/2]; result negated at the end
               neg_in = 1'b0;
               if (a_wide > HALF_PI_Q13) begin
                  a_fold = a_wide - PI_Q13;
                  neg_in = 1'b1;
               end else if (a_wide < -HALF_PI_Q13) begin
                  a_fold = a_wide + PI_Q13;
                  neg_in = 1'b1;
               end
               cx_in   = CORDIC_GAIN_Q30;
               cy_in   = '0;
               cz_in   = {a_fold, 17'd0};
               step_in = '0;
               cst_in  = ST_ITER;
            end
         end
         ST_ITER: begin
            if (!cz_ff[CORD_W-1]) begin
               cx_in = cx_ff - sh_y;
               cy_in = cy_ff + sh_x;
               cz_in = cz_ff - atan_q30(step_ff);
            end else begin
               cx_in = cx_ff + sh_y;
               cy_in = cy_ff - sh_x;
               cz_in = cz_ff + atan_q30(step_ff);
            end
            step_in = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(STEPS_EFF - 1))
               cst_in = ST_FINISH;
         end
         ST_FINISH: begin
            next_cos_in = to_q16(neg_ff ? -cx_ff : cx_ff);
            next_sin_in = to_q16(neg_ff ? -cy_ff : cy_ff);
            cst_in      = ST_IDLE;
         end
         default: ;
      endcase
      if (angle_wr)
         cst_in = ST_LOAD;
   end

   always_ff @(posedge clock) begin
      if (reset)
         cst_ff <= ST_LOAD;
      else
         cst_ff <= cst_in;
      step_ff     <= step_in;
      cx_ff       <= cx_in;
      cy_ff       <= cy_in;
      cz_ff       <= cz_in;
      neg_ff      <= neg_in;
      next_cos_ff <= next_cos_in;
      next_sin_ff <= next_sin_in;
   end

   // ---------------- point pipeline ----------------
   logic      s1_vld_ff, s2_vld_ff, s3_vld_ff, s4_vld_ff;
   logic      s1_last_ff, s2_last_ff, s3_last_ff, s4_last_ff;
   logic      trig_ready_ff, trig_ready_in;
   trig_type  cur_cos_ff, cur_sin_ff, cur_cos_in, cur_sin_in;
   coord_type s1_x_ff, s1_y_ff;
   trig_type  s1_c_ff, s1_s_ff;
   logic signed [PROD_W-1:0] cx_prod_ff, sy_prod_ff, sx_prod_ff, cy_prod_ff;
   logic signed [RND_W-1:0]  rx_ff, ry_ff;
   coord_type out_x_ff, out_y_ff;
   logic signed [SUM_W-1:0]  sum_x, sum_y;
   logic      adv, req_acc;

   assign adv        = !s4_vld_ff || rsp_tready;
   // the first point of a scan waits for a running CORDIC
   assign req_tready = adv && (trig_ready_ff || (cst_ff == ST_IDLE));
   assign req_acc    = req_tvalid && req_tready;

   always_comb begin
      trig_ready_in = trig_ready_ff;
      cur_cos_in    = cur_cos_ff;
      cur_sin_in    = cur_sin_ff;
      if (req_acc) begin
         if (!trig_ready_ff) begin
            cur_cos_in = next_cos_ff;
            cur_sin_in = next_sin_ff;
         end
         trig_ready_in = !req_tlast;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         trig_ready_ff <= 1'b0;
         cur_cos_ff    <= '0;
         cur_sin_ff    <= '0;
      end else begin
         trig_ready_ff <= trig_ready_in;
         cur_cos_ff    <= cur_cos_in;
         cur_sin_ff    <= cur_sin_in;
      end
   end

   assign sum_x = SUM_W'(cx_prod_ff) - SUM_W'(sy_prod_ff) + SUM_W'(32768);
   assign sum_y = SUM_W'(sx_prod_ff) + SUM_W'(cy_prod_ff) + SUM_W'(32768);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
         s4_vld_ff <= 1'b0;
      end else if (adv) begin
         s1_vld_ff <= req_acc;
         s2_vld_ff <= s1_vld_ff;
         s3_vld_ff <= s2_vld_ff;
         s4_vld_ff <= s3_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         // stage 1: point and the trig pair of its scan
         s1_x_ff    <= req_tdata[COORD_W-1:0];
         s1_y_ff    <= req_tdata[2*COORD_W-1:COORD_W];
         s1_last_ff <= req_tlast;
         s1_c_ff    <= trig_ready_ff ? cur_cos_ff : next_cos_ff;
         s1_s_ff    <= trig_ready_ff ? cur_sin_ff : next_sin_ff;
         // stage 2: products
         cx_prod_ff <= PROD_W'(s1_c_ff) * PROD_W'(s1_x_ff);
         sy_prod_ff <= PROD_W'(s1_s_ff) * PROD_W'(s1_y_ff);
         sx_prod_ff <= PROD_W'(s1_s_ff) * PROD_W'(s1_x_ff);
         cy_prod_ff <= PROD_W'(s1_c_ff) * PROD_W'(s1_y_ff);
         s2_last_ff <= s1_last_ff;
         // stage 3: sums rounded back to Q16.16
         rx_ff      <= RND_W'(sum_x >>> 16);
         ry_ff      <= RND_W'(sum_y >>> 16);
         s3_last_ff <= s2_last_ff;
         // stage 4: translate and saturate
         out_x_ff   <= sat32(FIN_W'(rx_ff) + FIN_W'(offset_x_ff));
         out_y_ff   <= sat32(FIN_W'(ry_ff) + FIN_W'(offset_y_ff));
         s4_last_ff <= s3_last_ff;
      end
   end

   assign rsp_tvalid = s4_vld_ff;
   assign rsp_tdata  = {out_y_ff, out_x_ff};
   assign rsp_tlast  = s4_last_ff;

   // ---------------- assertions ----------------
   `ASSERT_CLK(a_scan_start_trig_done, clock, reset,
      (req_acc && !trig_ready_ff) |-> (cst_ff == ST_IDLE), "scan started during CORDIC run")
   `ASSERT_CLK(a_tiny_angle_identity, clock, reset,
      ((cst_ff == ST_LOAD) && tiny_angle) |=> (next_cos_ff == ONE_Q16 && next_sin_ff == '0),
      "near-zero angle did not give identity rotation")
   `ASSERT_ALWAYS(a_trig_in_range, clock, reset,
      (cst_ff != ST_IDLE) || (next_cos_ff <= ONE_Q16 && next_cos_ff >= -ONE_Q16 &&
       next_sin_ff <= ONE_Q16 && next_sin_ff >= -ONE_Q16), "trig value out of range")
   `ASSERT_CLK(a_stage_advance, clock, reset,
      (s1_vld_ff && adv) |=> s2_vld_ff, "pipeline stage dropped a point")

endmodule

### dv/tb_point_cloud_rigid_transform_unit.sv
// Self-checking testbench for point_cloud_rigid_transform_unit: directed table, then random scans.
// Predicts rotation (CORDIC cosine/sine) plus translation per point beat; checks rsp in order.
// Depends on pcrt_pkg and the RTL top level.
module tb_point_cloud_rigid_transform_unit
   import pcrt_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int     HALF_PERIOD   = 2;
   localparam int     N_STEPS       = CORDIC_STEPS_DEFAULT;
   localparam int     TARGET_ITEMS  = 1700;
   localparam int     IDLE_LIMIT    = 2000;
   localparam int     SETTLE_CYCLES = 8;
   localparam int     FORCED_HOLD   = 300;
   localparam longint SAT_MAX       = 64'sd2147483647;
   localparam longint SAT_MIN       = -64'sd2147483648;
   localparam coord_type C_MAX      = 32'sh7FFFFFFF;
   localparam coord_type C_MIN      = 32'sh80000000;
   localparam logic [CSR_INDEX_W-1:0] REG_UNUSED = 2'd3;

   localparam longint ARCTAN_Q30 [ATAN_ENTRIES] = '{
      64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76, 64'h01FFD55B,
      64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
      64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF, 64'h00003FFF, 64'h00001FFF,
      64'h00000FFF, 64'h000007FF, 64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F
   };

   typedef struct {
      coord_type x;
      coord_type y;
      logic      is_last;
   } point_beat_type;

   typedef struct {
      bit                     is_cfg;
      logic [CSR_INDEX_W-1:0] idx;
      logic [CSR_DATA_W-1:0]  wdata;
      coord_type              px;
      coord_type              py;
      bit                     is_last;
      bit                     typed;
      coord_type              ex;
      coord_type              ey;
   } stim_row_type;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [2*COORD_W-1:0]   req_tdata  = '0;
   logic                   req_tlast  = 1'b0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [2*COORD_W-1:0]   rsp_tdata;
   logic                   rsp_tlast;
   logic                   csr_wen    = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index  = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata  = '0;

   // predictor state
   longint pose_off_x, pose_off_y;
   int     pose_angle;
   longint rot_cos, rot_sin;
   bit     rot_valid;

   point_beat_type expected_points[$];
   stim_row_type   directed_rows[$];
   point_beat_type due_point;
   int          mismatch_count = 0;
   int          items_sent     = 0;
   int          results_seen   = 0;
   bit          sender_bursty  = 1'b0;

   // receiver pacing
   int hold_left  = 0;
   int mode_left  = 0;
   bit rcv_bursty = 1'b0;

   int idle_cycles = 0;

   point_cloud_rigid_transform_unit #(.CORDIC_STEPS(N_STEPS)) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),   // [31:0] point_x, [63:32] point_y
      .req_tlast  (req_tlast),   // last_point
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),   // [31:0] out_x, [63:32] out_y
      .rsp_tlast  (rsp_tlast),   // out_last
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #(HALF_PERIOD) clock = ~clock;

   // ---------------- predictor ----------------
   function automatic longint q16_round(longint v);
      longint r;
      r = (v + 64'sd8192) >>> 14;
      if (r > 64'sd65536) r = 64'sd65536;
      if (r < -64'sd65536) r = -64'sd65536;
      return r;
   endfunction

   function automatic void compute_rotation();
      int     a;
      bit     flip;
      int     steps;
      longint x, y, z, nx;
      a     = pose_angle;
      flip  = 1'b0;
      steps = (N_STEPS > ATAN_ENTRIES) ? ATAN_ENTRIES : N_STEPS;
      if (a >= -int'(TINY_ANGLE) && a <= int'(TINY_ANGLE)) begin
         // tiny angle: translate only
         rot_cos = 64'sd65536;
         rot_sin = 0;
         return;
      end
      if (a > int'(HALF_PI_Q13)) begin
         a    = a - int'(PI_Q13);
         flip = 1'b1;
      end else if (a < -int'(HALF_PI_Q13)) begin
         a    = a + int'(PI_Q13);
         flip = 1'b1;
      end
      x = longint'(CORDIC_GAIN_Q30);
      y = 0;
      z = longint'(a) * 64'sd131072;
      for (int i = 0; i < steps; i++) begin
         if (z >= 0) begin
            nx = x - (y >>> i);
            y  = y + (x >>> i);
            z  = z - ARCTAN_Q30[i];
         end else begin
            nx = x + (y >>> i);
            y  = y - (x >>> i);
            z  = z + ARCTAN_Q30[i];
         end
         x = nx;
      end
      if (flip) begin
         x = -x;
         y = -y;
      end
      rot_cos = q16_round(x);
      rot_sin = q16_round(y);
   endfunction

   function automatic coord_type round_offset_sat(longint sum, longint off);
      longint r;
      r = ((sum + 64'sd32768) >>> 16) + off;
      if (r > SAT_MAX) r = SAT_MAX;
      if (r < SAT_MIN) r = SAT_MIN;
      return coord_type'(r);
   endfunction

   function automatic point_beat_type transform_point(coord_type px, coord_type py,
                                                      bit is_last);
      point_beat_type p;
      longint         lx, ly;
      if (!rot_valid) begin
         compute_rotation();
         rot_valid = 1'b1;
      end
      lx        = longint'(px);
      ly        = longint'(py);
      p.x       = round_offset_sat(rot_cos * lx - rot_sin * ly, pose_off_x);
      p.y       = round_offset_sat(rot_sin * lx + rot_cos * ly, pose_off_y);
      p.is_last = is_last;
      if (is_last) rot_valid = 1'b0;
      return p;
   endfunction

   function automatic void apply_reg(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] d);
      case (idx)
         REG_OFFSET_X:       pose_off_x = longint'($signed(d));
         REG_OFFSET_Y:       pose_off_y = longint'($signed(d));
         REG_ROTATION_ANGLE: pose_angle = int'($signed(d[ANGLE_W-1:0]));
         default: ;
      endcase
   endfunction

   // ---------------- stimulus helpers ----------------
   function automatic void add_cfg(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] d);
      directed_rows.push_back('{1'b1, idx, d, '0, '0, 1'b0, 1'b0, '0, '0});
   endfunction

   function automatic void add_pt(coord_type px, coord_type py, bit is_last, bit typed,
                                  coord_type ex, coord_type ey);
      directed_rows.push_back('{1'b0, REG_OFFSET_X, '0, px, py, is_last, typed, ex, ey});
   endfunction

   function automatic int pick_gap();
      int r;
      if (sender_bursty) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic coord_type pick_coord();
      case ($urandom_range(0, 9))
         0:       return C_MAX;
         1:       return C_MIN;
         2:       return '0;
         3, 4, 5: return coord_type'($urandom);
         default: return coord_type'(int'($urandom_range(0, 1 << 21)) - (1 << 20));
      endcase
   endfunction

   function automatic logic [CSR_DATA_W-1:0] pick_offset();
      case ($urandom_range(0, 7))
         0:       return C_MAX;
         1:       return C_MIN;
         2:       return '0;
         3, 4:    return $urandom;
         default: return CSR_DATA_W'(int'($urandom_range(0, 1 << 23)) - (1 << 22));
      endcase
   endfunction

   function automatic logic [CSR_DATA_W-1:0] pick_angle();
      logic [15:0] upper;
      int          a;
      upper = 16'($urandom);
      case ($urandom_range(0, 11))
         0:       a = 0;
         1:       a = 8;
         2:       a = -8;
         3:       a = 9;
         4:       a = -9;
         5:       a = int'(PI_Q13);
         6:       a = -int'(PI_Q13);
         7:       a = ($urandom_range(0, 1) != 0) ? int'(HALF_PI_Q13) : -int'(HALF_PI_Q13) - 1;
         8:       a = int'($signed(16'($urandom)));
         default: a = int'($urandom_range(0, 51472)) - 25736;
      endcase
      // upper bits are don't-care for the angle register
      return {upper, 16'(a)};
   endfunction

   task automatic write_reg(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] d);
      csr_wen   <= 1'b1;
      csr_index <= idx;
      csr_wdata <= d;
      @(posedge clock);
      apply_reg(idx, d);
      csr_wen <= 1'b0;
      @(posedge clock);
   endtask

   // drop valid, wait for the pipeline to empty before touching registers
   task automatic settle_block();
      req_tvalid <= 1'b0;
      while (expected_points.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic send_point(coord_type px, coord_type py, bit is_last, bit typed,
                             coord_type ex, coord_type ey);
      int             gap;
      point_beat_type p;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {py, px};
      req_tlast  <= is_last;
      do @(posedge clock); while (!req_tready);
      p = transform_point(px, py, is_last);
      if (typed) begin
         p.x = ex;
         p.y = ey;
      end
      expected_points.push_back(p);
      items_sent++;
   endtask

   task automatic report_mismatch(string field, longint got, longint want);
      $display("MISMATCH %s: got %0d expected %0d at %0t", field, got, want, $realtime);
      mismatch_count++;
   endtask

   // ---------------- receiver and checker ----------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            results_seen++;
            if (expected_points.size() == 0) begin
               report_mismatch("unexpected beat, x", longint'($signed(rsp_tdata[31:0])), 0);
            end else begin
               due_point = expected_points.pop_front();
               if (rsp_tdata[31:0] !== due_point.x)
                  report_mismatch("out_x", longint'($signed(rsp_tdata[31:0])),
                                  longint'(due_point.x));
               if (rsp_tdata[63:32] !== due_point.y)
                  report_mismatch("out_y", longint'($signed(rsp_tdata[63:32])),
                                  longint'(due_point.y));
               if (rsp_tlast !== due_point.is_last)
                  report_mismatch("out_last", longint'(rsp_tlast), longint'(due_point.is_last));
            end
            // one long back-pressure stretch, well inside the first random phase
            if (results_seen == 120) hold_left = FORCED_HOLD;
         end
         if (mode_left == 0) begin
            rcv_bursty = ($urandom_range(0, 2) == 0);
            mode_left  = $urandom_range(20, 200);
         end else begin
            mode_left--;
         end
         if (hold_left == 0 && $urandom_range(0, 999) == 0)
            hold_left = $urandom_range(100, 250);
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (rcv_bursty) begin
            rsp_tready <= 1'b1;
         end else if ($urandom_range(0, 99) < 30) begin
            hold_left  = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40)
                                                       : $urandom_range(0, 2);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // ---------------- watchdog ----------------
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == IDLE_LIMIT) begin
         $display("watchdog: no beat accepted for %0d cycles", IDLE_LIMIT);
         $display("tb_point_cloud_rigid_transform_unit failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // ---------------- main sequence ----------------
   initial begin
      stim_row_type row;
      int           phase_len;
      bit           first_phase;

      pose_off_x = 0;
      pose_off_y = 0;
      pose_angle = 0;
      rot_cos    = 0;
      rot_sin    = 0;
      rot_valid  = 1'b0;

      // after reset: angle 0, zero offsets, points pass through unchanged
      add_pt('0, '0, 1'b0, 1'b1, '0, '0);
      add_pt(C_MAX, C_MIN, 1'b0, 1'b1, C_MAX, C_MIN);
      add_pt(-32'sd1, 32'sd1, 1'b1, 1'b1, -32'sd1, 32'sd1);
      // extreme offsets: saturation both ways, then cancellation
      add_cfg(REG_OFFSET_X, C_MAX);
      add_cfg(REG_OFFSET_Y, C_MIN);
      add_pt(C_MAX, C_MIN, 1'b0, 1'b1, C_MAX, C_MIN);
      add_pt(C_MIN, C_MAX, 1'b1, 1'b1, -32'sd1, -32'sd1);
      // tiny-angle edges: translate only
      add_cfg(REG_OFFSET_X, '0);
      add_cfg(REG_OFFSET_Y, '0);
      add_cfg(REG_ROTATION_ANGLE, 32'd8);
      add_pt(32'sd12345, -32'sd6789, 1'b1, 1'b1, 32'sd12345, -32'sd6789);
      add_cfg(REG_ROTATION_ANGLE, 32'hFFFF_FFF8);
      add_pt(C_MIN, C_MAX, 1'b1, 1'b1, C_MIN, C_MAX);
      // first angle that rotates
      add_cfg(REG_ROTATION_ANGLE, 32'd9);
      add_pt(32'sd65536, '0, 1'b0, 1'b0, '0, '0);
      add_pt(C_MAX, C_MIN, 1'b1, 1'b0, '0, '0);
      // +/- pi
      add_cfg(REG_ROTATION_ANGLE, 32'(int'(PI_Q13)));
      add_pt(32'sd65536, 32'sd65536, 1'b0, 1'b0, '0, '0);
      add_pt(C_MIN, C_MIN, 1'b1, 1'b0, '0, '0);
      add_cfg(REG_ROTATION_ANGLE, 32'(-int'(PI_Q13)));
      add_pt(C_MAX, C_MAX, 1'b1, 1'b0, '0, '0);
      // pi/2 boundary; angle written mid-scan waits for the next scan
      add_cfg(REG_ROTATION_ANGLE, 32'(int'(HALF_PI_Q13)));
      add_pt(32'sd65536, '0, 1'b0, 1'b0, '0, '0);
      add_cfg(REG_ROTATION_ANGLE, 32'(int'(HALF_PI_Q13) + 1));
      add_pt('0, 32'sd65536, 1'b1, 1'b0, '0, '0);
      add_pt(32'sd65536, '0, 1'b1, 1'b0, '0, '0);
      add_cfg(REG_ROTATION_ANGLE, 32'(-int'(HALF_PI_Q13) - 1));
      add_pt(32'sd100000, -32'sd300000, 1'b1, 1'b0, '0, '0);
      // beyond pi: full 16-bit range
      add_cfg(REG_ROTATION_ANGLE, 32'h0000_7FFF);
      add_pt(32'sd65536, 32'sd65536, 1'b1, 1'b0, '0, '0);
      add_cfg(REG_ROTATION_ANGLE, 32'hFFFF_8000);
      add_pt(32'sd65536, -32'sd65536, 1'b1, 1'b0, '0, '0);
      // unused index is ignored; offsets change mid-scan take effect at once
      add_cfg(REG_UNUSED, 32'hFFFF_FFFF);
      add_pt(32'sd7, -32'sd7, 1'b0, 1'b0, '0, '0);
      add_cfg(REG_OFFSET_X, 32'h0001_2345);
      add_pt(32'sd70000, 32'sd70000, 1'b0, 1'b0, '0, '0);
      add_cfg(REG_OFFSET_Y, 32'hFFFE_0000);
      add_pt(-32'sd70000, 32'sd1, 1'b1, 1'b0, '0, '0);

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         if (row.is_cfg) begin
            settle_block();
            write_reg(row.idx, row.wdata);
         end else begin
            send_point(row.px, row.py, row.is_last, row.typed, row.ex, row.ey);
         end
      end

      first_phase = 1'b1;
      while (items_sent < TARGET_ITEMS) begin
         settle_block();
         if ($urandom_range(0, 2) != 0) write_reg(REG_OFFSET_X, pick_offset());
         if ($urandom_range(0, 2) != 0) write_reg(REG_OFFSET_Y, pick_offset());
         if ($urandom_range(0, 2) != 0) write_reg(REG_ROTATION_ANGLE, pick_angle());
         if ($urandom_range(0, 9) == 0) write_reg(REG_UNUSED, $urandom);
         phase_len     = first_phase ? 300 : $urandom_range(30, 120);
         sender_bursty = first_phase ? 1'b0 : ($urandom_range(0, 3) == 0);
         first_phase   = 1'b0;
         repeat (phase_len)
            send_point(pick_coord(), pick_coord(), $urandom_range(0, 7) == 0, 1'b0, '0, '0);
      end

      settle_block();
      repeat (10) @(posedge clock);
      if (mismatch_count == 0)
         $display("tb_point_cloud_rigid_transform_unit passed");
      else
         $display("tb_point_cloud_rigid_transform_unit failed");
      $finish;
   end

endmodule
